// File: src/record_deframer_crc32_assert.svh
// Assertion macros used by the deframer parser (rdc_parse).
`ifndef RECORD_DEFRAMER_CRC32_ASSERT_SVH
`define RECORD_DEFRAMER_CRC32_ASSERT_SVH

// Check a property on every rising clk edge outside reset.
`define RDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rdc_pkg.sv
// Types, constants and the CRC-32 byte step shared by the deframer modules.
`default_nettype none

package rdc_pkg;

  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RECORD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION    = 1'd1;

  localparam logic [31:0] MAX_RECORD_RESET = 32'd83886080;
  localparam logic [31:0] VERSION_RESET    = 32'd1;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES   = 32'hFFFFFFFF;
  localparam logic [31:0] MAGIC_WORD = 32'h5332544A;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_CLEAN_END  = 3'd1;
  localparam logic [2:0] ST_TORN       = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_BAD_HEADER = 3'd4;
  localparam logic [2:0] ST_VERSION    = 3'd5;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  record_kind;
    logic [2:0]  status;
    logic [31:0] record_length;
  } out_t;

  typedef struct packed {
    logic [31:0] max_record_bytes;
    logic [31:0] expected_version;
  } cfg_t;

  // Reflected CRC-32 over one byte, bitwise form of the table lookup.
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/rdc_fifo.sv
// Small register queue used between the front, the parser and the result side.
`default_nettype none

module rdc_fifo #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: src/rdc_parse.sv
// Back end: segment header check, record parsing and CRC-32 verification.
`default_nettype none
`include "record_deframer_crc32_assert.svh"

module rdc_parse (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rdc_pkg::cfg_t cfg,
  input  wire logic         in_ready,
  input  wire rdc_pkg::in_t in_item,
  input  wire logic         out_room,
  output logic              go,
  output logic              res_valid,
  output rdc_pkg::out_t     res
);

  typedef enum logic [2:0] {
    PH_SEGHDR  = 3'd0,
    PH_RECHDR  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_DROP    = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] len, len_next;
  logic [7:0]  typ, typ_next;
  logic [31:0] crc, crc_next;
  logic [31:0] scw, scw_next;

  logic [7:0]  b;
  logic        is_end;
  logic [31:0] pos_inc;
  logic [31:0] len_shift;
  logic [31:0] scw_shift;
  logic [31:0] crc_seed;
  logic [31:0] crc_step;

  assign go        = in_ready && out_room;
  assign b         = in_item.data_byte;
  assign is_end    = (in_item.command == rdc_pkg::CMD_END);
  assign pos_inc   = pos + 32'd1;
  assign len_shift = {len[23:0], b};
  assign scw_shift = {scw[23:0], b};
  assign crc_seed  = (phase == PH_RECHDR && pos == 32'd0) ? rdc_pkg::ALL_ONES : crc;
  assign crc_step  = rdc_pkg::crc_update(crc_seed, b);

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    len_next   = len;
    typ_next   = typ;
    crc_next   = crc;
    scw_next   = scw;
    res_valid  = 1'b0;
    res        = '0;
    if (go) begin
      if (is_end) begin
        res.kind = rdc_pkg::KIND_STATUS;
        unique case (phase)
          PH_SEGHDR: begin
            res_valid  = 1'b1;
            res.status = rdc_pkg::ST_BAD_HEADER;
          end
          PH_RECHDR: begin
            res_valid  = 1'b1;
            res.status = (pos == 32'd0) ? rdc_pkg::ST_CLEAN_END : rdc_pkg::ST_TORN;
          end
          PH_PAYLOAD, PH_CRC: begin
            res_valid         = 1'b1;
            res.status        = rdc_pkg::ST_TORN;
            res.record_kind   = typ;
            res.record_length = len;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
        // rearm for the next segment
        phase_next = PH_SEGHDR;
        pos_next   = '0;
        len_next   = '0;
        typ_next   = '0;
        crc_next   = rdc_pkg::ALL_ONES;
        scw_next   = '0;
      end else begin
        unique case (phase)
          PH_SEGHDR: begin
            if (pos < 32'd4) begin
              scw_next = scw_shift;
            end else if (pos < 32'd8) begin
              len_next = len_shift;
            end
            pos_next = pos_inc;
            if (pos == 32'd15) begin
              pos_next = '0;
              len_next = '0;
              scw_next = '0;
              res.kind = rdc_pkg::KIND_STATUS;
              if (scw != rdc_pkg::MAGIC_WORD) begin
                res_valid  = 1'b1;
                res.status = rdc_pkg::ST_BAD_HEADER;
                phase_next = PH_DROP;
              end else if (len != cfg.expected_version) begin
                res_valid  = 1'b1;
                res.status = rdc_pkg::ST_VERSION;
                phase_next = PH_DROP;
              end else begin
                phase_next = PH_RECHDR;
              end
            end
          end
          PH_RECHDR: begin
            if (pos == 32'd0) begin
              typ_next = b;
              len_next = '0;
            end else begin
              len_next = len_shift;
            end
            crc_next = crc_step;
            pos_next = pos_inc;
            if (pos == 32'd4) begin
              pos_next = '0;
              scw_next = '0;
              if (len_shift > cfg.max_record_bytes) begin
                res_valid         = 1'b1;
                res.kind          = rdc_pkg::KIND_STATUS;
                res.status        = rdc_pkg::ST_BAD_LENGTH;
                res.record_kind   = typ;
                res.record_length = len_shift;
                phase_next        = PH_DROP;
              end else begin
                phase_next = (len_shift != '0) ? PH_PAYLOAD : PH_CRC;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_next          = crc_step;
            res_valid         = 1'b1;
            res.kind          = rdc_pkg::KIND_PAYLOAD;
            res.payload_byte  = b;
            res.record_kind   = typ;
            res.record_length = len;
            pos_next          = pos_inc;
            if (pos_inc == len) begin
              pos_next   = '0;
              scw_next   = '0;
              phase_next = PH_CRC;
            end
          end
          PH_CRC: begin
            scw_next = scw_shift;
            pos_next = pos_inc;
            if (pos == 32'd3) begin
              pos_next          = '0;
              res_valid         = 1'b1;
              res.kind          = rdc_pkg::KIND_STATUS;
              res.record_kind   = typ;
              res.record_length = len;
              if ((crc ^ rdc_pkg::ALL_ONES) == scw_shift) begin
                res.status = rdc_pkg::ST_OK;
                phase_next = PH_RECHDR;
              end else begin
                res.status = rdc_pkg::ST_TORN;
                phase_next = PH_DROP;
              end
            end
          end
          default: begin
            // drop bytes until the end item
            phase_next = PH_DROP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEGHDR;
      pos   <= '0;
      len   <= '0;
      typ   <= '0;
      crc   <= rdc_pkg::ALL_ONES;
      scw   <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      len   <= len_next;
      typ   <= typ_next;
      crc   <= crc_next;
      scw   <= scw_next;
    end
  end

  `RDC_ASSERT(a_payload_only_in_payload, !(res_valid && res.kind == rdc_pkg::KIND_PAYLOAD) || phase == PH_PAYLOAD, "payload item outside payload phase")
  `RDC_ASSERT_NEXT(a_end_rearms, go && is_end, phase == PH_SEGHDR && pos == '0 && crc == rdc_pkg::ALL_ONES, "end item did not rearm")
  `RDC_ASSERT_NEXT(a_drop_holds, phase == PH_DROP && !(go && is_end), phase == PH_DROP, "left drop without end item")
  `RDC_ASSERT(a_result_needs_room, !res_valid || out_room, "result produced with no room")

endmodule

`default_nettype wire

// File: src/record_deframer_crc32.sv
// Items pass the front queue and the parser; a result is queued as its item is taken.
// Throughput: one item per cycle; the parser takes an item whenever the input
// queue holds one and the result queue has a free slot.
// CRC-32 covers record header and payload bytes; length is checked at header end.
// Reset (rst, synchronous): queues empty, parser at segment header, CRC all ones,
// max_record_bytes = 83886080 and expected_version = 1.
`default_nettype none

module record_deframer_crc32 #(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire rdc_pkg::in_t                  item,
  output logic                               empty,
  input  wire logic                          pop,
  output rdc_pkg::out_t                      result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int unsigned IN_W  = $bits(rdc_pkg::in_t);
  localparam int unsigned OUT_W = $bits(rdc_pkg::out_t);

  rdc_pkg::cfg_t   cfg;
  logic            front_empty;
  logic [IN_W-1:0] front_bits;
  rdc_pkg::in_t    front_item;
  logic            back_full;
  logic            go;
  logic            res_valid;
  rdc_pkg::out_t   res;
  logic [OUT_W-1:0] result_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_record_bytes <= rdc_pkg::MAX_RECORD_RESET;
      cfg.expected_version <= rdc_pkg::VERSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rdc_pkg::CFG_MAX_RECORD: cfg.max_record_bytes <= cfg_data;
        rdc_pkg::CFG_VERSION:    cfg.expected_version <= cfg_data;
        default:                 cfg.max_record_bytes <= cfg.max_record_bytes;
      endcase
    end
  end

  // Front: take items in and hold them for the parser.
  rdc_fifo #(
    .WIDTH (IN_W),
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (go),
    .rdata (front_bits),
    .empty (front_empty)
  );

  assign front_item = rdc_pkg::in_t'(front_bits);

  rdc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ready  (!front_empty),
    .in_item   (front_item),
    .out_room  (!back_full),
    .go        (go),
    .res_valid (res_valid),
    .res       (res)
  );

  rdc_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (res),
    .full  (back_full),
    .pop   (pop),
    .rdata (result_bits),
    .empty (empty)
  );

  assign result = rdc_pkg::out_t'(result_bits);

endmodule

`default_nettype wire

// File: sim/tb_record_deframer_crc32.sv
// Self-checking testbench for the record deframer: queued segment stimulus, per-item prediction.
module tb_record_deframer_crc32;

  localparam int SEG_HDR_BYTES = 16;
  localparam int REC_HDR_BYTES = 5;
  localparam int CRC_BYTES     = 4;
  localparam int SHORT_BODY    = 16;

  typedef enum logic [2:0] {PH_SEG_HDR, PH_REC_HDR, PH_BODY, PH_CRC, PH_DROP} parse_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  rdc_pkg::in_t item = '0;
  logic empty;
  logic pop = 1'b0;
  rdc_pkg::out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Parser state as the block should hold it.
  parse_phase_t dp_phase;
  logic [31:0] dp_pos, dp_len, dp_crc, dp_word;
  logic [7:0] dp_type;
  logic [31:0] max_len_reg, version_reg;

  rdc_pkg::in_t pending_items[$];
  rdc_pkg::out_t expected_results[$];
  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int idle_pct = 20;
  int push_gap = 0;
  int pop_gap = 0;
  int failures = 0;
  int items_queued = 0;
  int n_accepted = 0;
  int n_payload = 0;
  int n_settings = 0;
  int n_status[8] = '{default: 0};

  always #5 clk = ~clk;

  record_deframer_crc32 DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [31:0] crc32_shift(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ rdc_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void rearm_deframer();
    dp_phase = PH_SEG_HDR;
    dp_pos = '0;
    dp_len = '0;
    dp_type = '0;
    dp_crc = rdc_pkg::ALL_ONES;
    dp_word = '0;
  endfunction

  function automatic bit deframe_item(input rdc_pkg::in_t it, output rdc_pkg::out_t res);
    bit fire;
    logic [7:0] b;
    fire = 1'b0;
    res = '0;
    b = it.data_byte;
    if (it.command == rdc_pkg::CMD_END) begin
      case (dp_phase)
        PH_SEG_HDR: begin
          fire = 1'b1;
          res.kind = rdc_pkg::KIND_STATUS;
          res.status = rdc_pkg::ST_BAD_HEADER;
        end
        PH_REC_HDR: begin
          fire = 1'b1;
          res.kind = rdc_pkg::KIND_STATUS;
          res.status = (dp_pos == 0) ? rdc_pkg::ST_CLEAN_END : rdc_pkg::ST_TORN;
        end
        PH_BODY, PH_CRC: begin
          fire = 1'b1;
          res.kind = rdc_pkg::KIND_STATUS;
          res.record_kind = dp_type;
          res.status = rdc_pkg::ST_TORN;
          res.record_length = dp_len;
        end
        default: ; // error already reported
      endcase
      rearm_deframer();
    end else begin
      case (dp_phase)
        PH_SEG_HDR: begin
          if (dp_pos < 4) dp_word = {dp_word[23:0], b};
          else if (dp_pos < 8) dp_len = {dp_len[23:0], b};
          dp_pos = dp_pos + 1;
          if (dp_pos >= SEG_HDR_BYTES) begin
            dp_pos = '0;
            if (dp_word != rdc_pkg::MAGIC_WORD) begin
              fire = 1'b1;
              res.kind = rdc_pkg::KIND_STATUS;
              res.status = rdc_pkg::ST_BAD_HEADER;
              dp_phase = PH_DROP;
            end else if (dp_len != version_reg) begin
              fire = 1'b1;
              res.kind = rdc_pkg::KIND_STATUS;
              res.status = rdc_pkg::ST_VERSION;
              dp_phase = PH_DROP;
            end else begin
              dp_phase = PH_REC_HDR;
            end
            dp_len = '0;
            dp_word = '0;
          end
        end
        PH_REC_HDR: begin
          if (dp_pos == 0) begin
            dp_type = b;
            dp_len = '0;
            dp_crc = rdc_pkg::ALL_ONES;
          end else begin
            dp_len = {dp_len[23:0], b};
          end
          dp_crc = crc32_shift(dp_crc, b);
          dp_pos = dp_pos + 1;
          if (dp_pos >= REC_HDR_BYTES) begin
            dp_pos = '0;
            dp_word = '0;
            if (dp_len > max_len_reg) begin
              fire = 1'b1;
              res.kind = rdc_pkg::KIND_STATUS;
              res.record_kind = dp_type;
              res.status = rdc_pkg::ST_BAD_LENGTH;
              res.record_length = dp_len;
              dp_phase = PH_DROP;
            end else begin
              dp_phase = (dp_len != 0) ? PH_BODY : PH_CRC;
            end
          end
        end
        PH_BODY: begin
          dp_crc = crc32_shift(dp_crc, b);
          fire = 1'b1;
          res.kind = rdc_pkg::KIND_PAYLOAD;
          res.payload_byte = b;
          res.record_kind = dp_type;
          res.status = rdc_pkg::ST_OK;
          res.record_length = dp_len;
          dp_pos = dp_pos + 1;
          if (dp_pos >= dp_len) begin
            dp_pos = '0;
            dp_word = '0;
            dp_phase = PH_CRC;
          end
        end
        PH_CRC: begin
          dp_word = {dp_word[23:0], b};
          dp_pos = dp_pos + 1;
          if (dp_pos >= CRC_BYTES) begin
            dp_pos = '0;
            fire = 1'b1;
            res.kind = rdc_pkg::KIND_STATUS;
            res.record_kind = dp_type;
            res.record_length = dp_len;
            if ((dp_crc ^ rdc_pkg::ALL_ONES) == dp_word) begin
              res.status = rdc_pkg::ST_OK;
              dp_phase = PH_REC_HDR;
            end else begin
              res.status = rdc_pkg::ST_TORN;
              dp_phase = PH_DROP;
            end
          end
        end
        default: ; // drop until end of stream
      endcase
    end
    return fire;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // Sample at the rising edge: check results, predict accepted items, track registers.
  always @(posedge clk) begin
    rdc_pkg::out_t seen, want, pred;
    in_fire <= push && !full;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst) begin
      rearm_deframer();
      max_len_reg = rdc_pkg::MAX_RECORD_RESET;
      version_reg = rdc_pkg::VERSION_RESET;
    end else begin
      if (pop && !empty) begin
        seen = result;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: kind %0d status %0d",
                 seen.kind, seen.status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(seen.kind));
          check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
          check_field("record_kind", 32'(want.record_kind), 32'(seen.record_kind));
          check_field("status", 32'(want.status), 32'(seen.status));
          check_field("record_length", want.record_length, seen.record_length);
          if (want.kind == rdc_pkg::KIND_PAYLOAD) n_payload++;
          else n_status[want.status]++;
        end
      end
      if (push && !full) begin
        n_accepted++;
        if (deframe_item(item, pred)) expected_results.push_back(pred);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdc_pkg::CFG_MAX_RECORD: max_len_reg = cfg_data;
          rdc_pkg::CFG_VERSION:    version_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Item driver: hold an item until taken, otherwise idle in bursts or feed the next one.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (push_gap > 0) begin
        push <= 1'b0;
        push_gap <= push_gap - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        push <= 1'b0;
        push_gap <= $urandom_range(0, 5);
      end else if (pending_items.size() != 0) begin
        item <= pending_items.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: stall in bursts.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      pop <= 1'b0;
      pop_gap <= $urandom_range(0, 5);
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic void queue_item(input logic cmd, input logic [7:0] b);
    rdc_pkg::in_t it;
    it.command = cmd;
    it.data_byte = b;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || expected_results.size() != 0);
    // let items that give no result leave the block
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rdc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_setting(input logic [31:0] max_len, input logic [31:0] version,
                             input int idle_rate, input int n_items);
    int target, sel, cut, n_rec, r, k;
    logic [127:0] seg_hdr;
    logic [39:0] rec_hdr;
    logic [31:0] len, crc, stored;
    logic [7:0] b;
    bit stop;
    wait_quiet();
    write_reg(rdc_pkg::CFG_MAX_RECORD, max_len);
    write_reg(rdc_pkg::CFG_VERSION, version);
    idle_pct = idle_rate;
    n_settings++;
    target = items_queued + n_items;
    while (items_queued < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        // raw noise, end markers included
        repeat ($urandom_range(1, 12))
          queue_item(($urandom_range(0, 9) == 0) ? rdc_pkg::CMD_END : rdc_pkg::CMD_DATA,
                     8'($urandom));
      end else begin
        seg_hdr = {rdc_pkg::MAGIC_WORD, version, $urandom, $urandom};
        if (sel < 10) seg_hdr[127:96] ^= 32'd1 << $urandom_range(0, 31);
        else if (sel < 16) seg_hdr[95:64] ^= 32'd1 << $urandom_range(0, 31);
        cut = (sel >= 16 && sel < 20) ? $urandom_range(0, SEG_HDR_BYTES - 1) : SEG_HDR_BYTES;
        for (k = 0; k < cut; k++) queue_item(rdc_pkg::CMD_DATA, seg_hdr[127 - 8 * k -: 8]);
        stop = (cut < SEG_HDR_BYTES);
        n_rec = $urandom_range(0, 5);
        for (r = 0; r < n_rec && !stop; r++) begin
          sel = $urandom_range(0, 99);
          if (sel < 70) len = $urandom_range(0, 12);
          else if (sel < 78) len = max_len;
          else if (sel < 88) len = (max_len == rdc_pkg::ALL_ONES) ? $urandom : max_len + 1;
          else len = $urandom;
          rec_hdr = {8'($urandom), len};
          cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4) : REC_HDR_BYTES;
          crc = rdc_pkg::ALL_ONES;
          for (k = 0; k < cut; k++) begin
            b = rec_hdr[39 - 8 * k -: 8];
            queue_item(rdc_pkg::CMD_DATA, b);
            crc = crc32_shift(crc, b);
          end
          if (cut < REC_HDR_BYTES) begin
            stop = 1'b1;
          end else if (len > max_len || len > SHORT_BODY) begin
            // rejected, or too long to send whole: cut the segment short
            if (len <= max_len) repeat ($urandom_range(0, 6))
              queue_item(rdc_pkg::CMD_DATA, 8'($urandom));
            stop = 1'b1;
          end else begin
            for (k = 0; k < len; k++) begin
              b = 8'($urandom);
              queue_item(rdc_pkg::CMD_DATA, b);
              crc = crc32_shift(crc, b);
            end
            stored = crc ^ rdc_pkg::ALL_ONES;
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
              stored ^= 32'd1 << $urandom_range(0, 31);
              stop = 1'b1;
            end
            cut = (sel >= 10 && sel < 18) ? $urandom_range(0, CRC_BYTES - 1) : CRC_BYTES;
            for (k = 0; k < cut; k++) queue_item(rdc_pkg::CMD_DATA, stored[31 - 8 * k -: 8]);
            if (cut < CRC_BYTES) stop = 1'b1;
          end
        end
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4))
          queue_item(rdc_pkg::CMD_DATA, 8'($urandom));
        queue_item(rdc_pkg::CMD_END, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [127:0] seg_hdr;
    logic [39:0] rec_hdr;
    logic [31:0] crc;
    int k;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // End before any header, then a good header with one empty record and a clean end.
    queue_item(rdc_pkg::CMD_END, 8'hFF);
    seg_hdr = {rdc_pkg::MAGIC_WORD, rdc_pkg::VERSION_RESET, 64'h00FF_00FF_FF00_FF00};
    for (k = 0; k < SEG_HDR_BYTES; k++) queue_item(rdc_pkg::CMD_DATA, seg_hdr[127 - 8 * k -: 8]);
    rec_hdr = {8'hFF, 32'd0};
    crc = rdc_pkg::ALL_ONES;
    for (k = 0; k < REC_HDR_BYTES; k++) begin
      queue_item(rdc_pkg::CMD_DATA, rec_hdr[39 - 8 * k -: 8]);
      crc = crc32_shift(crc, rec_hdr[39 - 8 * k -: 8]);
    end
    crc = crc ^ rdc_pkg::ALL_ONES;
    for (k = 0; k < CRC_BYTES; k++) queue_item(rdc_pkg::CMD_DATA, crc[31 - 8 * k -: 8]);
    queue_item(rdc_pkg::CMD_END, 8'h00);

    run_setting(rdc_pkg::MAX_RECORD_RESET, rdc_pkg::VERSION_RESET, 20, 180);
    run_setting(32'd0, 32'd0, 30, 180);
    run_setting(rdc_pkg::ALL_ONES, rdc_pkg::ALL_ONES, 5, 180);
    run_setting(32'($urandom_range(1, 12)), $urandom, 25, 180);
    run_setting($urandom, $urandom, 15, 180);
    run_setting(rdc_pkg::MAX_RECORD_RESET, rdc_pkg::VERSION_RESET, 0, 180);
    wait_quiet();

    $display("Ran %0d items under %0d register settings; checked %0d payload bytes.",
             n_accepted, n_settings, n_payload);
    $display("Statuses: ok %0d, clean end %0d, torn %0d, bad length %0d, bad header %0d, version %0d",
             n_status[rdc_pkg::ST_OK], n_status[rdc_pkg::ST_CLEAN_END],
             n_status[rdc_pkg::ST_TORN], n_status[rdc_pkg::ST_BAD_LENGTH],
             n_status[rdc_pkg::ST_BAD_HEADER], n_status[rdc_pkg::ST_VERSION]);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rdc_pkg.sv
src/rdc_fifo.sv
src/rdc_parse.sv
src/record_deframer_crc32.sv
sim/tb_record_deframer_crc32.sv
